// ===== hdl/crcpls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 prefix search package
// Shared widths, constants, the queue entry type and the bytewise CRC update.
// ----------------------------------------------------------------------------
package crcpls_pkg;

    localparam int DATA_W  = 8;
    localparam int COUNT_W = 17;
    localparam int CRC_W   = 32;

    localparam logic [CRC_W-1:0]   CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]   CRC_ONES  = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_CAP = 17'h1_FFFF;

    // Search modes of the mode register.
    localparam logic MODE_SEARCH   = 1'b0;
    localparam logic MODE_CHECKSUM = 1'b1;

    // Register indexes of the configuration port.
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    // One classified byte, passed from the front end to the CRC engine.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               first;
        logic               last;
        logic               absorbed;
        logic [COUNT_W-1:0] count;
    } q_entry_t;

    // Reflected CRC-32 update by one byte, one bit per step.
    function automatic logic [CRC_W-1:0] crc_absorb(input logic [CRC_W-1:0] crc_in,
                                                    input logic [DATA_W-1:0] byte_in);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, byte_in};
        for (int k = 0; k < DATA_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcpls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 prefix search front end
// Accepts bytes, tracks the run length and marks which bytes are absorbed.
// ----------------------------------------------------------------------------
module crcpls_front
    import crcpls_pkg::*;
#(
    parameter logic [COUNT_W-1:0] LIMIT = 17'd65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              first_byte,
    input  logic              last_byte,
    output q_entry_t          entry
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_base;
    logic               absorbed;
    logic [COUNT_W-1:0] count_after;

    // A first mark restarts the count; bytes past the limit are not counted.
    always_comb
    begin
        count_base  = first_byte ? '0 : count_reg;
        absorbed    = (count_base < LIMIT);
        count_after = absorbed ? count_base + 1'b1 : count_base;

        entry.data     = data_byte;
        entry.first    = first_byte;
        entry.last     = last_byte;
        entry.absorbed = absorbed;
        entry.count    = count_after;

        count_next = count_reg;
        if (accept)
        begin
            count_next = last_byte ? '0 : count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/crcpls_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 prefix search queue
// Two-entry queue between the front end and the CRC engine.
// ----------------------------------------------------------------------------
module crcpls_queue
    import crcpls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t head
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = fill_reg[1];
    assign not_empty = (fill_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Pointer and fill updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/crcpls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 prefix search engine
// Updates the running CRC, runs the prefix search and holds the result.
// ----------------------------------------------------------------------------
module crcpls_back
    import crcpls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CRC_W-1:0]   target_crc,
    input  logic               mode,
    input  logic               q_not_empty,
    input  q_entry_t           q_head,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               res_found,
    output logic [COUNT_W-1:0] res_length,
    output logic [CRC_W-1:0]   res_crc
);

    logic [CRC_W-1:0]   crc_reg;
    logic [CRC_W-1:0]   crc_next;
    logic               done_reg;
    logic               done_next;
    logic               valid_reg;
    logic               valid_next;
    logic               found_reg;
    logic               found_next;
    logic [COUNT_W-1:0] length_reg;
    logic [COUNT_W-1:0] length_next;
    logic [CRC_W-1:0]   out_crc_reg;
    logic [CRC_W-1:0]   out_crc_next;

    logic [CRC_W-1:0]   crc_base;
    logic               done_base;
    logic [CRC_W-1:0]   crc_new;
    logic [CRC_W-1:0]   fin;
    logic               match;
    logic               emit;

    // Take an entry whenever the result register is free or being drained.
    assign q_pop = q_not_empty && (!valid_reg || res_ready);

    // CRC update and search decision for the entry at the queue head.
    always_comb
    begin
        crc_base  = q_head.first ? CRC_ONES : crc_reg;
        done_base = q_head.first ? 1'b0 : done_reg;
        crc_new   = q_head.absorbed ? crc_absorb(crc_base, q_head.data) : crc_base;
        fin       = ~crc_new;
        match     = (mode == MODE_SEARCH) && q_head.absorbed && !done_base
                    && (fin == target_crc);

        emit         = 1'b0;
        found_next   = found_reg;
        length_next  = length_reg;
        out_crc_next = out_crc_reg;
        if (mode == MODE_SEARCH)
        begin
            if (match)
            begin
                emit         = 1'b1;
                found_next   = 1'b1;
                length_next  = q_head.count;
                out_crc_next = target_crc;
            end
            else if (q_head.last && !done_base)
            begin
                emit         = 1'b1;
                found_next   = 1'b0;
                length_next  = '0;
                out_crc_next = fin;
            end
        end
        else if (q_head.last)
        begin
            emit         = 1'b1;
            found_next   = 1'b0;
            length_next  = q_head.count;
            out_crc_next = fin;
        end

        crc_next   = crc_reg;
        done_next  = done_reg;
        valid_next = valid_reg && !res_ready;
        if (q_pop)
        begin
            crc_next   = q_head.last ? CRC_ONES : crc_new;
            done_next  = q_head.last ? 1'b0 : (done_base || match);
            valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_ONES;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload is loaded only when a result is produced.
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            found_reg   <= found_next;
            length_reg  <= length_next;
            out_crc_reg <= out_crc_next;
        end
    end

    assign res_valid  = valid_reg;
    assign res_found  = found_reg;
    assign res_length = length_reg;
    assign res_crc    = out_crc_reg;

    // The end of a run returns the CRC and the search flag to their start values.
    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_head.last |=> (crc_reg == CRC_ONES) && !done_reg)
        else $error("run state not cleared after last byte");

    // A reported match always carries a non-empty prefix.
    a_found_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found |-> (res_length != '0))
        else $error("match reported with zero length");

    // A match inside a run stops the search for the rest of that run.
    a_match_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && match && !q_head.last |=> done_reg)
        else $error("search not stopped after match");

    // Nothing is taken from the queue while a stalled result is held.
    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !q_pop)
        else $error("entry taken while result stalled");

endmodule

// ===== hdl/crc32_prefix_length_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 prefix length search
// Running IEEE 802.3 CRC-32 over framed bytes with a search for the shortest
// prefix whose CRC equals a target, or the CRC of a whole run.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_ stream channel (tuser marks the first byte of a run,
//   tlast the last one). Results leave on the m_ stream channel: tuser is the
//   found flag, tdata holds the prefix length and the finished CRC.
//   target_crc (index 0) and mode (index 1) are written through the cfg_ port,
//   which the user must do only while no transaction is in flight; the block has no check for this.
//   Throughput is one byte per cycle while the output is not stalled: the bytewise
//   CRC update is one xor network in the engine, fed from a two-entry queue.
//   An accepted byte is stored in a queue slot; its result is then loaded into
//   the result register, which drives m_tvalid.
//   Reset clears the run state, the queue and both registers.
//   When the receiver stalls, the result is held, the engine stops and the
//   queue fills; s_tready drops once the queue holds two bytes.
// ----------------------------------------------------------------------------
module crc32_prefix_length_search
    import crcpls_pkg::*;
#(
    parameter int MAX_LEN = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // first_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [16:0] prefix_length, [48:17] crc_value, rest zero
    output logic        m_tuser,   // found
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [COUNT_W-1:0] LIMIT =
        (MAX_LEN > int'(COUNT_CAP)) ? COUNT_CAP : COUNT_W'(MAX_LEN);

    logic [CRC_W-1:0]   target_reg;
    logic               mode_reg;
    logic               accept;
    q_entry_t           front_entry;
    q_entry_t           q_head;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    logic               res_found;
    logic [COUNT_W-1:0] res_length;
    logic [CRC_W-1:0]   res_crc;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            mode_reg   <= MODE_SEARCH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET: target_reg <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    crcpls_front #(
        .LIMIT (LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .entry      (front_entry)
    );

    crcpls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    crcpls_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .target_crc  (target_reg),
        .mode        (mode_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_found   (res_found),
        .res_length  (res_length),
        .res_crc     (res_crc)
    );

    assign m_tuser = res_found;
    assign m_tdata = {7'd0, res_crc, res_length};

endmodule
